@@ rtl/sha_pkg.sv @@
package sha_pkg;

  typedef enum logic [1:0] {
    REQ_CHECK  = 2'd0,
    REQ_CREATE = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_DELPROC = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_HOLE = 3'd1,
    ST_NO_MEM  = 3'd2,
    ST_LIMIT   = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [1:0] CFG_MEM_SIZE   = 2'd1;
  localparam logic [1:0] CFG_ZERO_SIZE  = 2'd2;
  localparam logic [1:0] CFG_MAX_SEGS   = 2'd3;

  localparam int unsigned ADDR_BITS  = 16;

  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

endpackage

@@ rtl/sha_ram.sv @@
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/segment_hole_allocator_top.sv @@
// Segment hole allocator: free-hole table kept sorted by address plus a
// segment table keyed by (pid, seg_id); first/best/worst fit placement with
// coalescing on free.
// Channels: request words enter on s_axis (req_type, pid, seg_id, seg_size),
// one result word per request leaves on m_axis (status, base_address,
// total_fits, contiguous_fits, freed_count). Config writes go through
// cfg_we_i / cfg_addr_i / cfg_data_i; the user must make them only while
// the block is idle; the block itself does not enforce it. Both tables live
// in single-port-read synchronous RAMs with a registered read. A request
// walks the tables one entry at a time, a read state then a use state per
// entry; a hole shift also moves one entry at a time the same way. A check
// runs the sum walk; a create adds a segment walk, a fit walk and a shift;
// a delete-process frees up to S slots, each with a hole walk and a shift.
// Only one request is in flight; s_axis_tready is high only in idle.
// Reset (and a memory_size write) runs a clearing pass over every slot of the
// segment table before the first request is taken.
// A stalled result holds in the output register until m_axis_tready.
module segment_hole_allocator_top #(
  parameter int unsigned SEGMENT_SLOTS = 64,
  parameter int unsigned HOLE_SLOTS    = 65
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [sha_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0], pid[17:2], seg_id[21:18], seg_size[37:22], zero pad
  input  logic [sha_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], base_address[18:3], total_fits[19], contiguous_fits[20],
  // freed_count[27:21], zero pad
  output logic [sha_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import sha_pkg::*;

  localparam int unsigned SW = $clog2(SEGMENT_SLOTS);
  localparam int unsigned HW = $clog2(HOLE_SLOTS);
  localparam int unsigned HC = $clog2(HOLE_SLOTS + 1);
  localparam int unsigned LW = ADDR_BITS + 1;
  localparam int unsigned SUMW = LW + HC;
  localparam int unsigned SEGW = 1 + 16 + 4 + ADDR_BITS + 16;
  localparam int unsigned HOLEW = ADDR_BITS + LW;
  localparam logic [LW-1:0] SPAN = LW'(1) << ADDR_BITS;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SUM_RD, S_SUM, S_SEG_RD, S_SEG, S_FIT_RD, S_FIT,
    S_TAKE, S_SHL_RD, S_SHL, S_SEGWR, S_DEL_RD, S_DEL, S_FR_RD, S_FR,
    S_FR_HI_RD, S_FR_HI, S_FR_APPLY, S_SHR_RD, S_SHR, S_FR_INS, S_OUT
  } state_e;

  state_e state_q;
  logic [1:0]  fit_q;
  logic [16:0] memsz_q;
  logic [15:0] zsz_q;
  logic [4:0]  maxs_q;
  logic [HC-1:0] hcnt_q;

  logic [1:0]  req_q;
  logic [15:0] pid_q;
  logic [3:0]  sid_q;
  logic [15:0] size_q;
  logic [SUMW-1:0] sum_q;
  logic tot_q, cont_q;
  logic [6:0] freed_q;
  logic [2:0] stat_q;
  logic [15:0] base_q;

  logic [SW:0] si_q;         // segment index
  logic [HC-1:0] hi_q;       // hole index
  logic [SW:0] slot_q;
  logic [SW:0] owned_q;
  logic [HC-1:0] c_q;
  logic c_ok_q;
  logic [LW-1:0] clen_q;
  logic [ADDR_BITS-1:0] cbase_q;
  // free path
  logic [ADDR_BITS-1:0] fb_q;
  logic [15:0] fl_q;
  logic [HC-1:0] fi_q;
  logic [ADDR_BITS-1:0] pbase_q;
  logic [LW-1:0] plen_q;
  logic [HOLEW-1:0] nh_q;    // hole at fi
  logic lo_q, hi_ok_q;
  logic [HC-1:0] shd_q;      // shift dest pointer
  logic shl_ret_q;           // shift-left return: 0 create, 1 free

  // memories
  logic seg_we, hole_we;
  logic [SW-1:0] seg_wa, seg_ra;
  logic [SEGW-1:0] seg_wd, seg_rd;
  logic [HW-1:0] hole_wa, hole_ra;
  logic [HOLEW-1:0] hole_wd, hole_rd;

  sha_ram #(.Width(SEGW), .Depth(SEGMENT_SLOTS)) u_seg_ram (
    .clk_i, .we_i(seg_we), .waddr_i(seg_wa), .wdata_i(seg_wd),
    .raddr_i(seg_ra), .rdata_o(seg_rd)
  );
  sha_ram #(.Width(HOLEW), .Depth(HOLE_SLOTS)) u_hole_ram (
    .clk_i, .we_i(hole_we), .waddr_i(hole_wa), .wdata_i(hole_wd),
    .raddr_i(hole_ra), .rdata_o(hole_rd)
  );

  // segment word fields
  logic r_v;
  logic [15:0] r_pid;
  logic [3:0] r_sid;
  logic [ADDR_BITS-1:0] r_base;
  logic [15:0] r_len;
  assign {r_v, r_pid, r_sid, r_base, r_len} = seg_rd;
  logic [ADDR_BITS-1:0] h_base;
  logic [LW-1:0] h_len;
  assign {h_base, h_len} = hole_rd;

  // table init values
  logic [LW-1:0] mem_cl, zero_cl;
  always_comb begin
    mem_cl = (LW'(memsz_q) > SPAN) ? SPAN : LW'(memsz_q);
    zero_cl = (LW'(zsz_q) > mem_cl) ? mem_cl : LW'(zsz_q);
  end

  wire in_acc  = s_axis_tvalid && s_axis_tready;
  wire out_acc = m_axis_tvalid && m_axis_tready;
  wire fits    = h_len >= LW'(size_q);
  wire seg_hit = r_v && r_pid == pid_q;
  wire [LW-1:0] fend = LW'(fb_q) + LW'(fl_q);

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = state_q == S_OUT;
  assign m_axis_tdata = OUT_DATA_W'({freed_q, cont_q, tot_q, base_q, stat_q});

  // memory port control
  always_comb begin
    seg_we = 1'b0; seg_wa = si_q[SW-1:0]; seg_wd = '0; seg_ra = si_q[SW-1:0];
    hole_we = 1'b0; hole_wa = hi_q[HW-1:0]; hole_wd = '0; hole_ra = hi_q[HW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        seg_we = 1'b1;
        hole_we = si_q == '0;
        hole_wa = '0;
        hole_wd = {zero_cl[ADDR_BITS-1:0], mem_cl - zero_cl};
      end
      S_TAKE: begin
        hole_we = clen_q != LW'(size_q);
        hole_wa = c_q[HW-1:0];
        hole_wd = {cbase_q + ADDR_BITS'(size_q), clen_q - LW'(size_q)};
      end
      S_SHL: begin
        hole_we = 1'b1; hole_wa = shd_q[HW-1:0]; hole_wd = hole_rd;
      end
      S_SEGWR: begin
        seg_we = 1'b1; seg_wa = slot_q[SW-1:0];
        seg_wd = {1'b1, pid_q, sid_q, cbase_q, size_q};
      end
      S_DEL: begin
        // clear the slot only on a match
        seg_we = seg_hit && (req_q == REQ_DELPROC || r_sid == sid_q);
        seg_wd = '0;
      end
      S_FR_APPLY: begin
        hole_we = 1'b1;
        if (lo_q && hi_ok_q) begin
          hole_wa = HW'(fi_q - 1'b1);
          hole_wd = {pbase_q, plen_q + LW'(fl_q) + nh_q[LW-1:0]};
        end else if (lo_q) begin
          hole_wa = HW'(fi_q - 1'b1);
          hole_wd = {pbase_q, plen_q + LW'(fl_q)};
        end else begin
          hole_wa = fi_q[HW-1:0];
          hole_wd = {fb_q, nh_q[LW-1:0] + LW'(fl_q)};
        end
      end
      S_SHR_RD: hole_ra = HW'(shd_q - 1'b1);
      S_SHR: begin
        hole_we = 1'b1; hole_wa = shd_q[HW-1:0]; hole_wd = hole_rd;
      end
      S_FR_INS: begin
        hole_we = 1'b1; hole_wa = fi_q[HW-1:0]; hole_wd = {fb_q, LW'(fl_q)};
      end
      S_SHL_RD: hole_ra = HW'(shd_q + 1'b1);
      S_FR_HI_RD: hole_ra = fi_q[HW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      fit_q <= FIT_FIRST; memsz_q <= 17'd4096; zsz_q <= 16'd128; maxs_q <= 5'd16;
      hcnt_q <= '0; si_q <= '0; hi_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_FIT_POLICY: fit_q <= cfg_data_i[1:0];
          CFG_MEM_SIZE: begin
            memsz_q <= cfg_data_i; state_q <= S_CLEAR; si_q <= '0;
          end
          CFG_ZERO_SIZE: zsz_q <= cfg_data_i[15:0];
          CFG_MAX_SEGS:  maxs_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (!(cfg_we_i && cfg_addr_i == CFG_MEM_SIZE)) begin
        unique case (state_q)
          S_CLEAR: begin
            if (si_q == '0) hcnt_q <= (zero_cl < mem_cl) ? HC'(1) : '0;
            if (si_q == (SW+1)'(SEGMENT_SLOTS - 1)) state_q <= S_IDLE;
            si_q <= si_q + 1'b1;
          end
          S_IDLE: if (in_acc) begin
            req_q <= s_axis_tdata[1:0]; pid_q <= s_axis_tdata[17:2];
            sid_q <= s_axis_tdata[21:18]; size_q <= s_axis_tdata[37:22];
            sum_q <= '0; tot_q <= 1'b0; cont_q <= 1'b0; freed_q <= '0;
            stat_q <= (s_axis_tdata[1:0] == REQ_DELETE) ? ST_MISSING : ST_OK;
            base_q <= '0;
            hi_q <= '0; si_q <= '0; slot_q <= (SW+1)'(SEGMENT_SLOTS);
            owned_q <= '0; c_ok_q <= 1'b0;
            if (s_axis_tdata[1:0] == REQ_CHECK || s_axis_tdata[1:0] == REQ_CREATE)
              state_q <= S_SUM_RD;
            else state_q <= S_DEL_RD;
          end
          S_SUM_RD: begin
            if (hi_q >= hcnt_q) begin
              tot_q <= sum_q >= SUMW'(size_q);
              if (req_q == REQ_CHECK) begin
                stat_q <= cont_q ? ST_OK : ((sum_q >= SUMW'(size_q)) ? ST_NO_HOLE : ST_NO_MEM);
                state_q <= S_OUT;
              end else state_q <= S_SEG_RD;
            end else state_q <= S_SUM;
          end
          S_SUM: begin
            sum_q <= sum_q + SUMW'(h_len);
            if (fits) cont_q <= 1'b1;
            hi_q <= hi_q + 1'b1; state_q <= S_SUM_RD;
          end
          S_SEG_RD: begin
            if (si_q == (SW+1)'(SEGMENT_SLOTS)) begin
              if (sid_q == '0 || owned_q >= (SW+1)'(maxs_q) ||
                  slot_q == (SW+1)'(SEGMENT_SLOTS)) begin
                stat_q <= ST_LIMIT; state_q <= S_OUT;
              end else begin
                hi_q <= '0; state_q <= S_FIT_RD;
              end
            end else state_q <= S_SEG;
          end
          S_SEG: begin
            if (r_v) begin
              if (r_pid == pid_q) owned_q <= owned_q + 1'b1;
            end else if (slot_q == (SW+1)'(SEGMENT_SLOTS)) slot_q <= si_q;
            si_q <= si_q + 1'b1; state_q <= S_SEG_RD;
          end
          S_FIT_RD: begin
            if (hi_q >= hcnt_q) begin
              if (!c_ok_q) begin
                stat_q <= tot_q ? ST_NO_HOLE : ST_NO_MEM; state_q <= S_OUT;
              end else state_q <= S_TAKE;
            end else state_q <= S_FIT;
          end
          S_FIT: begin
            state_q <= S_FIT_RD;
            // first fit stops at the first hole that fits
            if (fits && !c_ok_q && fit_q != FIT_BEST && fit_q != FIT_WORST)
              hi_q <= hcnt_q;
            else hi_q <= hi_q + 1'b1;
            if (fits && (!c_ok_q || (fit_q == FIT_BEST && h_len < clen_q) ||
                (fit_q == FIT_WORST && h_len > clen_q))) begin
              c_ok_q <= 1'b1; c_q <= hi_q; clen_q <= h_len; cbase_q <= h_base;
            end
          end
          S_TAKE: begin
            base_q <= 16'(cbase_q);
            if (clen_q == LW'(size_q)) begin
              shd_q <= c_q; shl_ret_q <= 1'b0; state_q <= S_SHL_RD;
            end else state_q <= S_SEGWR;
          end
          S_SHL_RD: begin
            if (shd_q + 1'b1 >= hcnt_q) begin
              hcnt_q <= hcnt_q - 1'b1;
              state_q <= shl_ret_q ? S_DEL_RD : S_SEGWR;
            end else state_q <= S_SHL;
          end
          S_SHL: begin
            shd_q <= shd_q + 1'b1; state_q <= S_SHL_RD;
          end
          S_SEGWR: state_q <= S_OUT;
          S_DEL_RD: begin
            if (si_q == (SW+1)'(SEGMENT_SLOTS) ||
                (req_q == REQ_DELETE && (sid_q == '0 || freed_q != '0)))
              state_q <= S_OUT;
            else state_q <= S_DEL;
          end
          S_DEL: begin
            if (seg_hit && (req_q == REQ_DELPROC || r_sid == sid_q)) begin
              freed_q <= freed_q + 1'b1; stat_q <= ST_OK;
              fb_q <= r_base; fl_q <= r_len;
              fi_q <= '0; hi_q <= '0; lo_q <= 1'b0;
              state_q <= (r_len == '0) ? S_DEL_RD : S_FR_RD;
            end else state_q <= S_DEL_RD;
            si_q <= si_q + 1'b1;
          end
          S_FR_RD: begin
            if (hi_q >= hcnt_q) begin
              fi_q <= hi_q; state_q <= S_FR_HI_RD;
            end else state_q <= S_FR;
          end
          S_FR: begin
            if (h_base < fb_q) begin
              pbase_q <= h_base; plen_q <= h_len;
              lo_q <= LW'(h_base) + h_len == LW'(fb_q);
              hi_q <= hi_q + 1'b1; state_q <= S_FR_RD;
            end else begin
              fi_q <= hi_q; state_q <= S_FR_HI_RD;
            end
          end
          S_FR_HI_RD: state_q <= S_FR_HI;
          S_FR_HI: begin
            nh_q <= hole_rd;
            hi_ok_q <= fi_q < hcnt_q && fend == LW'(h_base);
            if (!lo_q && !(fi_q < hcnt_q && fend == LW'(h_base))) begin
              if (hcnt_q >= HC'(HOLE_SLOTS)) state_q <= S_DEL_RD;
              else begin
                shd_q <= hcnt_q; state_q <= S_SHR_RD;
              end
            end else state_q <= S_FR_APPLY;
          end
          S_FR_APPLY: begin
            if (lo_q && hi_ok_q) begin
              shd_q <= fi_q; shl_ret_q <= 1'b1; state_q <= S_SHL_RD;
            end else state_q <= S_DEL_RD;
          end
          S_SHR_RD: state_q <= (shd_q > fi_q) ? S_SHR : S_FR_INS;
          S_SHR: begin
            shd_q <= shd_q - 1'b1; state_q <= S_SHR_RD;
          end
          S_FR_INS: begin
            hcnt_q <= hcnt_q + 1'b1; state_q <= S_DEL_RD;
          end
          S_OUT: if (out_acc) state_q <= S_IDLE;
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_one_hot_hs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("in and out both open");
  a_hcnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HC'(HOLE_SLOTS)) else $error("hole count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
`endif
endmodule

@@ tb/segment_hole_allocator_top_test.sv @@
module segment_hole_allocator_top_test;
  import sha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 64;
  localparam int HOLES = 65;
  localparam int SPAN = 65536;
  // settle time after the last result before a config write; the clearing
  // pass after a memory_size write is covered by the tready handshake
  localparam int SETTLE = 600;

  // first member sits in the top bits: freed_count high, status low
  typedef struct packed {
    logic [6:0]  freed;
    logic        cont;
    logic        tot;
    logic [15:0] base;
    logic [2:0]  status;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  segment_hole_allocator_top dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  int unsigned pol, mem_sz, zero_sz, max_segs;
  int unsigned hb[HOLES], hl[HOLES];
  int unsigned nholes;
  bit sv[SLOTS];
  int unsigned so[SLOTS], sn[SLOTS], sbase[SLOTS], slen[SLOTS];

  logic [IN_DATA_W-1:0] pending_words[$];
  result_t expected_results[$];
  int errors = 0;
  bit feeding = 1'b1; // driver may take from the queue
  int unsigned pid_pool[4];

  function automatic void rebuild_tables();
    int unsigned m, z;
    m = mem_sz > SPAN ? SPAN : mem_sz;
    z = zero_sz > m ? m : zero_sz;
    nholes = 0;
    if (z < m) begin
      hb[0] = z;
      hl[0] = m - z;
      nholes = 1;
    end
    foreach (sv[i]) sv[i] = 1'b0;
  endfunction

  function automatic void release_range(int unsigned b, int unsigned len);
    int unsigned i;
    bit lo, hi;
    if (len == 0) return;
    i = 0;
    while (i < nholes && hb[i] < b) i++;
    lo = i > 0 && hb[i-1] + hl[i-1] == b;
    hi = i < nholes && b + len == hb[i];
    if (lo && hi) begin
      hl[i-1] += len + hl[i];
      for (int k = i; k + 1 < nholes; k++) begin
        hb[k] = hb[k+1];
        hl[k] = hl[k+1];
      end
      nholes--;
    end else if (lo) begin
      hl[i-1] += len;
    end else if (hi) begin
      hb[i] = b;
      hl[i] += len;
    end else begin
      if (nholes >= HOLES) return;
      for (int k = nholes; k > i; k--) begin
        hb[k] = hb[k-1];
        hl[k] = hl[k-1];
      end
      hb[i] = b;
      hl[i] = len;
      nholes++;
    end
  endfunction

  function automatic result_t allocate_request(logic [IN_DATA_W-1:0] w);
    req_e req;
    int unsigned pid, sid, size, sum, owned, slot, c;
    result_t r;
    req = req_e'(w[1:0]);
    pid = w[17:2];
    sid = w[21:18];
    size = w[37:22];
    r = '0;
    sum = 0;
    if (req == REQ_CHECK || req == REQ_CREATE) begin
      for (int i = 0; i < nholes; i++) begin
        sum += hl[i];
        if (hl[i] >= size) r.cont = 1'b1;
      end
      r.tot = sum >= size;
    end
    case (req)
      REQ_CHECK: begin
        r.status = r.cont ? ST_OK : (r.tot ? ST_NO_HOLE : ST_NO_MEM);
      end
      REQ_CREATE: begin
        owned = 0;
        slot = SLOTS;
        for (int i = 0; i < SLOTS; i++) begin
          if (sv[i]) begin
            if (so[i] == pid) owned++;
          end else if (slot == SLOTS) slot = i;
        end
        if (sid == 0 || owned >= max_segs || slot == SLOTS) begin
          r.status = ST_LIMIT;
        end else begin
          c = HOLES;
          for (int i = 0; i < nholes; i++) begin
            if (hl[i] < size) continue;
            if (c == HOLES) begin
              c = i;
              if (pol != FIT_BEST && pol != FIT_WORST) break;
            end else if (pol == FIT_BEST && hl[i] < hl[c]) c = i;
            else if (pol == FIT_WORST && hl[i] > hl[c]) c = i;
          end
          if (c == HOLES) begin
            r.status = r.tot ? ST_NO_HOLE : ST_NO_MEM;
          end else begin
            r.status = ST_OK;
            r.base = hb[c];
            sbase[slot] = hb[c];
            if (hl[c] == size) begin
              for (int k = c; k + 1 < nholes; k++) begin
                hb[k] = hb[k+1];
                hl[k] = hl[k+1];
              end
              nholes--;
            end else begin
              hb[c] += size;
              hl[c] -= size;
            end
            sv[slot] = 1'b1;
            so[slot] = pid;
            sn[slot] = sid;
            slen[slot] = size;
          end
        end
      end
      REQ_DELETE: begin
        r.status = ST_MISSING;
        if (sid != 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (sv[i] && so[i] == pid && sn[i] == sid) begin
              sv[i] = 1'b0;
              release_range(sbase[i], slen[i]);
              r.status = ST_OK;
              r.freed = 1;
              break;
            end
          end
        end
      end
      default: begin
        r.status = ST_OK;
        for (int i = 0; i < SLOTS; i++) begin
          if (sv[i] && so[i] == pid) begin
            sv[i] = 1'b0;
            release_range(sbase[i], slen[i]);
            r.freed++;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_request(req_e req, int unsigned pid,
                                                        int unsigned sid, int unsigned size);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[1:0] = req;
    w[17:2] = pid;
    w[21:18] = sid;
    w[37:22] = size;
    return w;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // driver: one word at a time from pending_words
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(allocate_request(s_axis_tdata));
        send_gap = gap_len();
        s_axis_tvalid <= 1'b0;
      end else if (!s_axis_tvalid) begin
        if (send_gap > 0) send_gap--;
        else if (feeding && pending_words.size() > 0) begin
          s_axis_tdata <= pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  // monitor plus receiver stalls
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[27:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.base !== want.base ||
              got.tot !== want.tot || got.cont !== want.cont ||
              got.freed !== want.freed || m_axis_tdata[31:28] !== 4'b0) begin
            $display("%0t: expected %p, actual %p", $time, want, got);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap = gap_len();
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // config write, only while idle; predictor mirrors it at the same edge
  task automatic write_reg(logic [1:0] idx, int unsigned val);
    wait_drained();
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FIT_POLICY: pol = val & 3;
      CFG_MEM_SIZE: begin
        mem_sz = val & 17'h1ffff;
        rebuild_tables();
      end
      CFG_ZERO_SIZE: zero_sz = val & 16'hffff;
      default: max_segs = val & 5'h1f;
    endcase
  endtask

  // well-formed traffic from a few pids with mostly small sizes
  task automatic queue_random(int n);
    int unsigned p, pid, sz;
    req_e req;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(99);
      pid = $urandom_range(99) < 90 ? pid_pool[$urandom_range(3)] : $urandom_range(65535);
      if (p < 45) req = REQ_CREATE;
      else if (p < 80) req = REQ_DELETE;
      else if (p < 92) req = REQ_CHECK;
      else req = REQ_DELPROC;
      case ($urandom_range(9))
        0: sz = $urandom_range(65535);
        1: sz = 0;
        2, 3: sz = $urandom_range(2048);
        default: sz = $urandom_range(200);
      endcase
      pending_words.push_back(pack_request(req, pid,
          $urandom_range(99) < 95 ? $urandom_range(15, 1) : 0, sz));
    end
  endtask

  initial begin
    pol = FIT_FIRST;
    mem_sz = 4096;
    zero_sz = 128;
    max_segs = 16;
    rebuild_tables();
    foreach (pid_pool[i]) pid_pool[i] = $urandom_range(65535);
    pid_pool[0] = 16'hffff;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default tables
    pending_words.push_back(pack_request(REQ_CHECK, 0, 0, 0));
    pending_words.push_back(pack_request(REQ_CHECK, 0, 0, 65535));
    pending_words.push_back(pack_request(REQ_CHECK, 0, 0, 3968));
    pending_words.push_back(pack_request(REQ_CREATE, 7, 0, 10));        // seg zero refused
    pending_words.push_back(pack_request(REQ_CREATE, 7, 1, 100));
    pending_words.push_back(pack_request(REQ_CREATE, 7, 2, 0));         // zero size
    pending_words.push_back(pack_request(REQ_CREATE, 7, 3, 200));
    pending_words.push_back(pack_request(REQ_CREATE, 65535, 15, 300));
    pending_words.push_back(pack_request(REQ_CREATE, 7, 1, 50));        // duplicate id
    pending_words.push_back(pack_request(REQ_DELETE, 7, 1, 0));         // lower middle hole
    pending_words.push_back(pack_request(REQ_CHECK, 0, 0, 3400));       // fragmented
    pending_words.push_back(pack_request(REQ_CREATE, 7, 4, 65535));
    pending_words.push_back(pack_request(REQ_DELETE, 7, 0, 0));
    pending_words.push_back(pack_request(REQ_DELETE, 9, 5, 0));
    pending_words.push_back(pack_request(REQ_DELPROC, 1234, 0, 0));
    pending_words.push_back(pack_request(REQ_DELPROC, 7, 0, 0));
    pending_words.push_back(pack_request(REQ_DELETE, 65535, 15, 0));

    // pause the sender until everything is back
    wait_drained();
    write_reg(CFG_MAX_SEGS, 1);
    pending_words.push_back(pack_request(REQ_CREATE, 3, 1, 5));
    pending_words.push_back(pack_request(REQ_CREATE, 3, 2, 5));         // limit
    write_reg(CFG_MAX_SEGS, 0);
    pending_words.push_back(pack_request(REQ_CREATE, 4, 1, 5));
    write_reg(CFG_ZERO_SIZE, 65535);
    write_reg(CFG_MEM_SIZE, 0);                                          // no holes
    pending_words.push_back(pack_request(REQ_CHECK, 0, 0, 0));
    write_reg(CFG_MEM_SIZE, 131071);                                     // clamped
    write_reg(CFG_MAX_SEGS, 16);
    pending_words.push_back(pack_request(REQ_CREATE, 1, 1, 1));
    pending_words.push_back(pack_request(REQ_CHECK, 0, 0, 1));
    write_reg(CFG_FIT_POLICY, 3);                                        // acts as first fit
    write_reg(CFG_ZERO_SIZE, 0);
    write_reg(CFG_MEM_SIZE, 65536);
    pending_words.push_back(pack_request(REQ_CREATE, 1, 1, 65535));
    pending_words.push_back(pack_request(REQ_CREATE, 1, 2, 1));
    pending_words.push_back(pack_request(REQ_CHECK, 0, 0, 0));

    // random phases across settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FIT_POLICY, ph % 4);
      write_reg(CFG_ZERO_SIZE, ph == 5 ? 65535 : $urandom_range(300));
      write_reg(CFG_MAX_SEGS, ph == 3 ? 1 : (ph == 6 ? 31 : $urandom_range(16, 1)));
      write_reg(CFG_MEM_SIZE, ph == 2 ? 1 : (ph == 4 ? 65536 : $urandom_range(8192, 256)));
      queue_random(250);
    end
    wait_drained();
    feeding = 1'b0;
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #80ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
